@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked assertions on clk with reset rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, expr, msg)
`define ASSERT_IMPLY(label, ante, cons, msg)
`endif
`endif

@@ sv/dts_pkg.sv @@
// ----------------------------------------------------------------------------
// dts_pkg
// Types, constants and helpers shared by the directional shading block.
// ----------------------------------------------------------------------------
package dts_pkg;

    localparam int MAX_WIDTH   = 2048;
    localparam int ADDR_W      = $clog2(MAX_WIDTH);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [2:0] REG_FRAME_WIDTH   = 3'd0;
    localparam logic [2:0] REG_FRAME_HEIGHT  = 3'd1;
    localparam logic [2:0] REG_SHADE_X_GAIN  = 3'd2;
    localparam logic [2:0] REG_SHADE_Y_GAIN  = 3'd3;
    localparam logic [2:0] REG_CONTRAST_GAIN = 3'd4;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    localparam logic [11:0] RST_FRAME_WIDTH   = 12'd640;
    localparam logic [15:0] RST_FRAME_HEIGHT  = 16'd480;
    localparam logic [15:0] RST_SHADE_X_GAIN  = 16'd11585;
    localparam logic [15:0] RST_SHADE_Y_GAIN  = 16'd53951;
    localparam logic [16:0] RST_CONTRAST_GAIN = 17'd32768;

    localparam logic [16:0] LUMA_R = 17'd19595;
    localparam logic [16:0] LUMA_G = 17'd38470;
    localparam logic [16:0] LUMA_B = 17'd7471;

    typedef struct packed {
        logic        kind;
        logic [7:0]  red_in;
        logic [7:0]  green_in;
        logic [7:0]  blue_in;
        logic [7:0]  alpha_in;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  red_out;
        logic [7:0]  green_out;
        logic [7:0]  blue_out;
        logic [7:0]  alpha_out;
        logic        frame_last;
    } out_item_t;

    typedef struct packed {
        logic [11:0] frame_width;
        logic [15:0] frame_height;
        logic [15:0] shade_x_gain;
        logic [15:0] shade_y_gain;
        logic [16:0] contrast_gain;
    } cfg_t;

    typedef struct packed {
        logic              drain;
        logic              first;
        logic              has_right;
        logic              emit;
        logic              interior;
        logic              last;
        logic [ADDR_W-1:0] x;
        logic [31:0]       pixel;
    } dts_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic [23:0] luma(input logic [31:0] p);
        logic [24:0] sum;
        begin
            sum = 25'(p[7:0]) * 25'(LUMA_R) + 25'(p[15:8]) * 25'(LUMA_G)
                + 25'(p[23:16]) * 25'(LUMA_B);
            luma = sum[23:0];
        end
    endfunction

    function automatic logic [7:0] grey_weight(input logic [7:0] c);
        logic [8:0] dbl;
        logic [8:0] wt;
        begin
            dbl = {c, 1'b0};
            wt  = c[7] ? (9'd510 - dbl) : dbl;
            grey_weight = wt[7:0];
        end
    endfunction

    function automatic out_item_t to_out(input logic [31:0] p, input logic last);
        out_item_t o;
        begin
            o.red_out    = p[7:0];
            o.green_out  = p[15:8];
            o.blue_out   = p[23:16];
            o.alpha_out  = p[31:24];
            o.frame_last = last;
            to_out = o;
        end
    endfunction

endpackage

@@ sv/dts_ram.sv @@
// ----------------------------------------------------------------------------
// dts_ram
// Single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module dts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ sv/dts_fifo.sv @@
// ----------------------------------------------------------------------------
// dts_fifo
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
module dts_fifo import dts_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  dts_cmd_t  cmd,
    input  logic      pop,
    output dts_cmd_t  head,
    output q_status_t q_stat
);

    dts_cmd_t          mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign head         = mem_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == '0);

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= cmd;
        end
    end

endmodule

@@ sv/dts_front.sv @@
// ----------------------------------------------------------------------------
// dts_front
// Accepts input words, tracks frame position and queues pixel and drain work.
// ----------------------------------------------------------------------------
module dts_front import dts_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      pixel_valid,
    output logic      pixel_stall,
    input  in_item_t  pixel,
    input  q_status_t q_stat,
    output logic      push,
    output dts_cmd_t  cmd
);

    logic [ADDR_W-1:0] col_reg;
    logic [ADDR_W-1:0] col_next;
    logic [15:0]       row_reg;
    logic [15:0]       row_next;
    logic [ADDR_W-1:0] drain_reg;
    logic [ADDR_W-1:0] drain_next;

    logic [ADDR_W:0]   w_eff;
    logic [ADDR_W:0]   w_m1;
    logic [15:0]       h_eff;
    logic [15:0]       row_p1;
    logic              accept;
    logic              draining;
    logic [ADDR_W-1:0] px_x;
    logic [ADDR_W:0]   px_x_p1;
    logic              px_last;
    logic [ADDR_W-1:0] dr_x;
    logic [ADDR_W:0]   dr_x_p1;
    logic              dr_last;

    always_comb
    begin
        if (cfg.frame_width == '0)
        begin
            w_eff = (ADDR_W+1)'(1);
        end
        else if (cfg.frame_width > 12'(MAX_WIDTH))
        begin
            w_eff = (ADDR_W+1)'(MAX_WIDTH);
        end
        else
        begin
            w_eff = (ADDR_W+1)'(cfg.frame_width);
        end
    end

    assign w_m1     = w_eff - 1'b1;
    assign h_eff    = (cfg.frame_height == '0) ? 16'd1 : cfg.frame_height;
    assign row_p1   = row_reg + 16'd1;
    assign draining = (row_reg >= h_eff);

    assign px_x    = ({1'b0, col_reg} >= w_eff) ? w_m1[ADDR_W-1:0] : col_reg;
    assign px_x_p1 = {1'b0, px_x} + 1'b1;
    assign px_last = (px_x_p1 >= w_eff);
    assign dr_x    = ({1'b0, drain_reg} >= w_eff) ? w_m1[ADDR_W-1:0] : drain_reg;
    assign dr_x_p1 = {1'b0, dr_x} + 1'b1;
    assign dr_last = (dr_x_p1 >= w_eff);

    assign pixel_stall = q_stat.full;
    assign accept      = pixel_valid && !q_stat.full;
    assign push        = accept && ((pixel.kind == KIND_FLUSH) ? draining : !draining);

    always_comb
    begin
        cmd.drain     = (pixel.kind == KIND_FLUSH);
        cmd.first     = (px_x == '0);
        cmd.has_right = !px_last;
        cmd.emit      = (row_reg >= 16'd1);
        cmd.interior  = (row_reg >= 16'd2) && (px_x != '0) && !px_last;
        cmd.last      = dr_last;
        cmd.x         = (pixel.kind == KIND_FLUSH) ? dr_x : px_x;
        cmd.pixel     = {pixel.alpha_in, pixel.blue_in, pixel.green_in, pixel.red_in};
    end

    always_comb
    begin
        col_next   = col_reg;
        row_next   = row_reg;
        drain_next = drain_reg;
        if (push)
        begin
            if (pixel.kind == KIND_FLUSH)
            begin
                if (dr_last)
                begin
                    drain_next = '0;
                    row_next   = '0;
                    col_next   = '0;
                end
                else
                begin
                    drain_next = dr_x_p1[ADDR_W-1:0];
                end
            end
            else if (px_last)
            begin
                col_next = '0;
                row_next = row_p1;
                if (row_p1 >= h_eff)
                begin
                    drain_next = '0;
                end
            end
            else
            begin
                col_next = px_x_p1[ADDR_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            drain_reg <= '0;
        end
        else
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            drain_reg <= drain_next;
        end
    end

endmodule

@@ sv/dts_back.sv @@
// ----------------------------------------------------------------------------
// dts_back
// Runs queued work against the line stores and computes the shaded pixel.
// ----------------------------------------------------------------------------
module dts_back import dts_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  dts_cmd_t  head,
    input  q_status_t q_stat,
    output logic      pop,
    output logic      shade_valid,
    input  logic      shade_stall,
    output out_item_t shade
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_RD1  = 4'd1;
    localparam logic [3:0] ST_WR   = 4'd2;
    localparam logic [3:0] ST_LUMA = 4'd3;
    localparam logic [3:0] ST_MUL  = 4'd4;
    localparam logic [3:0] ST_SUM  = 4'd5;
    localparam logic [3:0] ST_PROD = 4'd6;
    localparam logic [3:0] ST_QUOT = 4'd7;
    localparam logic [3:0] ST_FIX  = 4'd8;
    localparam logic [3:0] ST_OUT  = 4'd9;

    logic [3:0]   state_reg;
    logic [3:0]   state_next;
    dts_cmd_t     cmd_reg;
    logic [31:0]  mx_reg;
    logic [31:0]  ux_reg;
    logic [31:0]  win0_reg;
    logic [31:0]  win1_reg;
    logic [31:0]  win2_reg;
    logic [31:0]  win0_next;
    logic [31:0]  win1_next;
    logic [31:0]  win2_next;
    logic [23:0]  lum_r_reg;
    logic [23:0]  lum_l_reg;
    logic [23:0]  lum_b_reg;
    logic [23:0]  lum_a_reg;
    logic [24:0]  cw_reg   [3];
    logic signed [40:0] px_reg;
    logic signed [40:0] py_reg;
    logic signed [27:0] t_reg;
    logic signed [53:0] p_reg [3];
    logic [16:0]  qoff_reg [3];
    logic [9:0]   k0_reg   [3];
    out_item_t    res_reg;
    logic         out_valid_reg;
    out_item_t    out_word_reg;

    logic [ADDR_W-1:0] m_raddr;
    logic [ADDR_W:0]   x_p1;
    logic [31:0]       m_rdata;
    logic [31:0]       u_rdata;
    logic              we;
    logic              out_free;

    logic signed [24:0] dx;
    logic signed [24:0] dy;
    logic signed [41:0] s_sum;
    logic signed [41:0] s_adj;
    logic signed [21:0] q_raw  [3];
    logic signed [21:0] q_sat  [3];
    logic signed [21:0] q_offs [3];
    logic [25:0]        q_mul  [3];
    logic [17:0]        rem    [3];
    logic [9:0]         k_adj  [3];
    logic signed [10:0] v      [3];
    logic [7:0]         chan   [3];

    assign x_p1     = {1'b0, cmd_reg.x} + 1'b1;
    assign m_raddr  = (state_reg == ST_IDLE) ? head.x : x_p1[ADDR_W-1:0];
    assign we       = (state_reg == ST_WR);
    assign pop      = (state_reg == ST_IDLE) && !q_stat.empty;
    assign out_free = !out_valid_reg || !shade_stall;
    assign shade_valid = out_valid_reg;
    assign shade       = out_word_reg;

    dts_ram #(.WIDTH(32), .DEPTH(MAX_WIDTH)) u_middle (
        .clk   (clk),
        .we    (we),
        .waddr (cmd_reg.x),
        .wdata (cmd_reg.pixel),
        .raddr (m_raddr),
        .rdata (m_rdata)
    );

    dts_ram #(.WIDTH(32), .DEPTH(MAX_WIDTH)) u_upper (
        .clk   (clk),
        .we    (we),
        .waddr (cmd_reg.x),
        .wdata (mx_reg),
        .raddr (head.x),
        .rdata (u_rdata)
    );

    always_comb
    begin
        if (cmd_reg.first)
        begin
            win0_next = '0;
            win1_next = mx_reg;
        end
        else
        begin
            win0_next = win1_reg;
            win1_next = win2_reg;
        end
        win2_next = cmd_reg.has_right ? m_rdata : '0;
    end

    always_comb
    begin
        dx    = $signed({1'b0, lum_r_reg}) - $signed({1'b0, lum_l_reg});
        dy    = $signed({1'b0, lum_b_reg}) - $signed({1'b0, lum_a_reg});
        s_sum = 42'(px_reg) + 42'(py_reg);
        s_adj = s_sum + (s_sum[41] ? 42'sd16383 : 42'sd0);
        for (int i = 0; i < 3; i++)
        begin
            q_raw[i] = p_reg[i][53:32];
            if (q_raw[i] > 22'sd65280)
            begin
                q_sat[i] = 22'sd65280;
            end
            else if (q_raw[i] < -22'sd65280)
            begin
                q_sat[i] = -22'sd65280;
            end
            else
            begin
                q_sat[i] = q_raw[i];
            end
            q_offs[i] = q_sat[i] + 22'sd65280;
            q_mul[i]  = 26'({q_offs[i][16:0], 8'b0}) + 26'(q_offs[i][16:0]);
            rem[i]    = 18'(qoff_reg[i]) - (18'({k0_reg[i], 8'b0}) - 18'(k0_reg[i]));
            k_adj[i]  = k0_reg[i] + ((rem[i] >= 18'd255) ? 10'd1 : 10'd0);
            v[i]      = $signed({3'b0, win1_reg[8*i +: 8]}) + $signed({1'b0, k_adj[i]})
                      - 11'sd256;
            if (v[i] < 11'sd0)
            begin
                chan[i] = 8'd0;
            end
            else if (v[i] > 11'sd255)
            begin
                chan[i] = 8'd255;
            end
            else
            begin
                chan[i] = v[i][7:0];
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    state_next = ST_RD1;
                end
            end
            ST_RD1:
            begin
                state_next = cmd_reg.drain ? ST_OUT : ST_WR;
            end
            ST_WR:
            begin
                if (!cmd_reg.emit)
                begin
                    state_next = ST_IDLE;
                end
                else if (cmd_reg.interior)
                begin
                    state_next = ST_LUMA;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_LUMA: state_next = ST_MUL;
            ST_MUL:  state_next = ST_SUM;
            ST_SUM:  state_next = ST_PROD;
            ST_PROD: state_next = ST_QUOT;
            ST_QUOT: state_next = ST_FIX;
            ST_FIX:  state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            win0_reg      <= '0;
            win1_reg      <= '0;
            win2_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!shade_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == ST_WR)
            begin
                win0_reg <= win0_next;
                win1_reg <= win1_next;
                win2_reg <= win2_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                cmd_reg <= head;
            end
            ST_RD1:
            begin
                mx_reg  <= m_rdata;
                ux_reg  <= u_rdata;
                res_reg <= to_out(m_rdata, cmd_reg.last);
            end
            ST_WR:
            begin
                res_reg <= to_out(win1_next, 1'b0);
            end
            ST_LUMA:
            begin
                lum_r_reg <= luma(win2_reg);
                lum_l_reg <= luma(win0_reg);
                lum_b_reg <= luma(cmd_reg.pixel);
                lum_a_reg <= luma(ux_reg);
                for (int i = 0; i < 3; i++)
                begin
                    cw_reg[i] <= 25'(cfg.contrast_gain) * 25'(grey_weight(win1_reg[8*i +: 8]));
                end
            end
            ST_MUL:
            begin
                px_reg <= 41'(dx) * 41'($signed(cfg.shade_x_gain));
                py_reg <= 41'(dy) * 41'($signed(cfg.shade_y_gain));
            end
            ST_SUM:
            begin
                t_reg <= s_adj[41:14];
            end
            ST_PROD:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    p_reg[i] <= 54'(t_reg) * 54'($signed({1'b0, cw_reg[i]}));
                end
            end
            ST_QUOT:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    qoff_reg[i] <= q_offs[i][16:0];
                    k0_reg[i]   <= q_mul[i][25:16];
                end
            end
            ST_FIX:
            begin
                res_reg <= {chan[0], chan[1], chan[2], win1_reg[31:24], 1'b0};
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_word_reg <= res_reg;
                end
            end
            default:
            begin
                cmd_reg <= cmd_reg;
            end
        endcase
    end

endmodule

@@ sv/directional_texture_shade.sv @@
// Order: a pixel is answered one row late. A queued word goes to the back end, which
// reads the line stores; a drained word then goes to output, a pixel is written back,
// and a border pixel goes to output while an interior pixel first runs the shade steps.
// Flow: the queue takes up to 4 words back to back; the back end then runs one word at
// a time and holds its output word while shade_stall is high.
// Reset: asynchronous active low; positions and control clear, registers load
// their defaults, line stores stay unwritten.
// ----------------------------------------------------------------------------
// directional_texture_shade
// Emboss style directional shading over a cross neighborhood, top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module directional_texture_shade import dts_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pixel_valid,
    output logic        pixel_stall,
    input  in_item_t    pixel,
    output logic        shade_valid,
    input  logic        shade_stall,
    output out_item_t   shade,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [16:0] cfg_data
);

    cfg_t      cfg_reg;
    q_status_t q_stat;
    dts_cmd_t  q_cmd;
    dts_cmd_t  q_head;
    logic      q_push;
    logic      q_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width   <= RST_FRAME_WIDTH;
            cfg_reg.frame_height  <= RST_FRAME_HEIGHT;
            cfg_reg.shade_x_gain  <= RST_SHADE_X_GAIN;
            cfg_reg.shade_y_gain  <= RST_SHADE_Y_GAIN;
            cfg_reg.contrast_gain <= RST_CONTRAST_GAIN;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:   cfg_reg.frame_width   <= cfg_data[11:0];
                REG_FRAME_HEIGHT:  cfg_reg.frame_height  <= cfg_data[15:0];
                REG_SHADE_X_GAIN:  cfg_reg.shade_x_gain  <= cfg_data[15:0];
                REG_SHADE_Y_GAIN:  cfg_reg.shade_y_gain  <= cfg_data[15:0];
                REG_CONTRAST_GAIN: cfg_reg.contrast_gain <= cfg_data;
                default:           cfg_reg               <= cfg_reg;
            endcase
        end
    end

    dts_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel       (pixel),
        .q_stat      (q_stat),
        .push        (q_push),
        .cmd         (q_cmd)
    );

    dts_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .cmd    (q_cmd),
        .pop    (q_pop),
        .head   (q_head),
        .q_stat (q_stat)
    );

    dts_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .head        (q_head),
        .q_stat      (q_stat),
        .pop         (q_pop),
        .shade_valid (shade_valid),
        .shade_stall (shade_stall),
        .shade       (shade)
    );

    `ASSERT_ALWAYS(a_no_overflow, !(q_stat.full && q_push), "push into full command queue")
    `ASSERT_ALWAYS(a_no_underflow, !(q_stat.empty && q_pop), "pop from empty command queue")
    `ASSERT_IMPLY(a_full_stalls, q_stat.full, pixel_stall, "full queue not stalling input")

endmodule

@@ tb/dts_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dts_checker
// Watches the pixel, shade and register channels of the directional shading
// block, predicts every shaded word from its own raster and line store model
// and compares each accepted shade word with the oldest predicted one.
// ----------------------------------------------------------------------------
module dts_checker import dts_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pixel_valid,
    input  logic        pixel_stall,
    input  in_item_t    pixel,
    input  logic        shade_valid,
    input  logic        shade_stall,
    input  out_item_t   shade,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [16:0] cfg_data,
    output int          fails,
    output int          pending
);

    localparam longint SHADE_DEN = longint'(255) << 32;

    logic [31:0]  upper_row [MAX_WIDTH];
    logic [31:0]  middle_row [MAX_WIDTH];
    logic [31:0]  win [3];
    int unsigned  col;
    int unsigned  row;
    int unsigned  drain_col;
    cfg_t         regs;
    out_item_t    shaded_words[$];

    function automatic int unsigned eff_width(input logic [11:0] fw);
        if (fw == 0)
            return 1;
        if (fw > MAX_WIDTH)
            return MAX_WIDTH;
        return fw;
    endfunction

    function automatic longint luma_of(input logic [31:0] p);
        return 19595 * longint'(p[7:0]) + 38470 * longint'(p[15:8])
             + 7471 * longint'(p[23:16]);
    endfunction

    function automatic logic [7:0] tone(input logic [7:0] c, input longint t,
                                        input logic [16:0] cg);
        longint d;
        longint n;
        longint q;
        d = 2 * longint'(c) - 255;
        if (d < 0)
            d = -d;
        n = longint'(c) * SHADE_DEN + t * (255 - d) * longint'(cg);
        if (n < 0)
            return 8'd0;
        q = n / SHADE_DEN;
        return (q > 255) ? 8'd255 : q[7:0];
    endfunction

    task automatic advance_raster(input in_item_t it);
        int unsigned w;
        int unsigned h;
        int unsigned x;
        logic [31:0] pix;
        logic [31:0] res;
        longint      s;
        longint      t;
        w = eff_width(regs.frame_width);
        h = (regs.frame_height == 0) ? 1 : regs.frame_height;
        if (it.kind == KIND_FLUSH) begin
            if (row < h)
                return;
            x = (drain_col >= w) ? w - 1 : drain_col;
            if (x + 1 >= w) begin
                shaded_words.push_back(to_out(middle_row[x], 1'b1));
                drain_col = 0;
                row = 0;
                col = 0;
            end
            else begin
                shaded_words.push_back(to_out(middle_row[x], 1'b0));
                drain_col = x + 1;
            end
            return;
        end
        if (row >= h)
            return;
        pix = {it.alpha_in, it.blue_in, it.green_in, it.red_in};
        x = (col >= w) ? w - 1 : col;
        if (x == 0) begin
            win[0] = 0;
            win[1] = middle_row[0];
            win[2] = (w > 1) ? middle_row[1] : 32'd0;
        end
        else begin
            win[0] = win[1];
            win[1] = win[2];
            win[2] = (x + 1 < w) ? middle_row[x + 1] : 32'd0;
        end
        if (row >= 1) begin
            res = win[1];
            if (row >= 2 && x >= 1 && x + 1 < w) begin
                s = (luma_of(win[2]) - luma_of(win[0])) * longint'($signed(regs.shade_x_gain))
                  + (luma_of(pix) - luma_of(upper_row[x])) * longint'($signed(regs.shade_y_gain));
                t = s / 16384;
                res = {win[1][31:24], tone(win[1][23:16], t, regs.contrast_gain),
                       tone(win[1][15:8], t, regs.contrast_gain),
                       tone(win[1][7:0], t, regs.contrast_gain)};
            end
            shaded_words.push_back(to_out(res, 1'b0));
        end
        upper_row[x] = middle_row[x];
        middle_row[x] = pix;
        if (x + 1 >= w) begin
            col = 0;
            row = row + 1;
            if (row >= h)
                drain_col = 0;
        end
        else begin
            col = x + 1;
        end
    endtask

    initial
    begin
        fails = 0;
        pending = 0;
        col = 0;
        row = 0;
        drain_col = 0;
        for (int i = 0; i < 3; i++)
            win[i] = 0;
        for (int i = 0; i < MAX_WIDTH; i++)
        begin
            upper_row[i] = 0;
            middle_row[i] = 0;
        end
        regs = {RST_FRAME_WIDTH, RST_FRAME_HEIGHT, RST_SHADE_X_GAIN,
                RST_SHADE_Y_GAIN, RST_CONTRAST_GAIN};
    end

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_FRAME_WIDTH:   regs.frame_width   = cfg_data[11:0];
                    REG_FRAME_HEIGHT:  regs.frame_height  = cfg_data[15:0];
                    REG_SHADE_X_GAIN:  regs.shade_x_gain  = cfg_data[15:0];
                    REG_SHADE_Y_GAIN:  regs.shade_y_gain  = cfg_data[15:0];
                    REG_CONTRAST_GAIN: regs.contrast_gain = cfg_data;
                    default: ;
                endcase
            end
            if (pixel_valid && !pixel_stall)
                advance_raster(pixel);
            if (shade_valid && !shade_stall) begin
                if (shaded_words.size() == 0) begin
                    $display("%0t: unexpected word, expected none, actual %h", $realtime, shade);
                    fails++;
                end
                else begin
                    want = shaded_words.pop_front();
                    if (shade.red_out !== want.red_out || shade.green_out !== want.green_out
                        || shade.blue_out !== want.blue_out
                        || shade.alpha_out !== want.alpha_out
                        || shade.frame_last !== want.frame_last) begin
                        $display("%0t: mismatch, expected r%h g%h b%h a%h l%b, actual r%h g%h b%h a%h l%b",
                                 $realtime, want.red_out, want.green_out, want.blue_out,
                                 want.alpha_out, want.frame_last, shade.red_out,
                                 shade.green_out, shade.blue_out, shade.alpha_out,
                                 shade.frame_last);
                        fails++;
                    end
                end
            end
            pending = shaded_words.size();
        end
    end

endmodule

@@ tb/directional_texture_shade_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// directional_texture_shade_tb
// Drives frames of pixels, flush words and register writes into the shading
// block under random idling and stall, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module directional_texture_shade_tb;
    import dts_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        pixel_valid;
    logic        pixel_stall;
    in_item_t    pixel;
    logic        shade_valid;
    logic        shade_stall;
    out_item_t   shade;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [16:0] cfg_data;
    int          fails;
    int          pending;
    bit          calm;
    int          random_pixels;

    directional_texture_shade uut (
        .clk(clk), .rst_n(rst_n),
        .pixel_valid(pixel_valid), .pixel_stall(pixel_stall), .pixel(pixel),
        .shade_valid(shade_valid), .shade_stall(shade_stall), .shade(shade),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    dts_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .pixel_valid(pixel_valid), .pixel_stall(pixel_stall), .pixel(pixel),
        .shade_valid(shade_valid), .shade_stall(shade_stall), .shade(shade),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fails(fails), .pending(pending)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    always @(posedge clk)
        shade_stall <= !calm && ($urandom_range(0, 99) < 34);

    task automatic send(input logic kind, input logic [31:0] p);
        while (!calm && $urandom_range(0, 99) < 34)
        begin
            pixel_valid <= 1'b0;
            @(posedge clk);
        end
        pixel_valid <= 1'b1;
        pixel <= {kind, p[7:0], p[15:8], p[23:16], p[31:24]};
        @(posedge clk);
        while (pixel_stall)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [16:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic setup(input logic [11:0] fw, input logic [15:0] fh, input logic [15:0] gx,
                         input logic [15:0] gy, input logic [16:0] cg);
        pixel_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
        write_reg(REG_FRAME_WIDTH, 17'(fw));
        write_reg(REG_FRAME_HEIGHT, 17'(fh));
        write_reg(REG_SHADE_X_GAIN, 17'(gx));
        write_reg(REG_SHADE_Y_GAIN, 17'(gy));
        write_reg(REG_CONTRAST_GAIN, cg);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] chan();
        case ($urandom_range(0, 7))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [31:0] any_pixel();
        return {chan(), chan(), chan(), chan()};
    endfunction

    task automatic run_frame(input int w, input int h, input bit noisy);
        for (int i = 0; i < w * h; i++)
        begin
            if (noisy && $urandom_range(0, 99) < 3)
                send(KIND_FLUSH, $urandom);
            send(KIND_PIXEL, any_pixel());
        end
        for (int i = 0; i < w; i++)
        begin
            if (noisy && $urandom_range(0, 99) < 5)
                send(KIND_PIXEL, $urandom);
            send(KIND_FLUSH, $urandom);
        end
    endtask

    function automatic logic [15:0] gain();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [16:0] contrast();
        case ($urandom_range(0, 5))
            0: return 17'd0;
            1: return 17'd65536;
            2: return 17'h1ffff;
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    initial
    begin
        int w;
        int h;
        rst_n = 1'b0;
        calm = 1'b0;
        pixel_valid = 1'b0;
        pixel = '0;
        shade_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        random_pixels = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        setup(12'd3, 16'd3, 16'h7fff, 16'h8000, 17'd65536);
        send(KIND_PIXEL, 32'h00000000);
        send(KIND_PIXEL, 32'hffffffff);
        send(KIND_PIXEL, 32'h00ff00ff);
        send(KIND_FLUSH, 32'h0);
        send(KIND_PIXEL, 32'hff00ff00);
        send(KIND_PIXEL, 32'h80808080);
        send(KIND_PIXEL, 32'h7f7f7f7f);
        send(KIND_PIXEL, 32'hffffffff);
        send(KIND_PIXEL, 32'h00000000);
        send(KIND_PIXEL, 32'hffffffff);
        send(KIND_FLUSH, 32'h0);
        send(KIND_PIXEL, 32'h12345678);
        send(KIND_FLUSH, 32'h0);
        send(KIND_FLUSH, 32'h0);
        setup(12'd0, 16'd0, 16'h8000, 16'h7fff, 17'h1ffff);
        send(KIND_PIXEL, 32'ha5a5a5a5);
        send(KIND_FLUSH, 32'h0);

        while (random_pixels < 700)
        begin
            calm = (random_pixels > 300 && random_pixels < 450);
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            h = $urandom_range(1, 6);
            setup(12'(w), 16'(h), gain(), gain(), contrast());
            run_frame(w, h, 1'b1);
            random_pixels += w * h;
        end
        calm = 1'b0;
        pixel_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (fails == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #(64'd20_000_000);
        $display("FAILED: results differ");
        $finish;
    end

endmodule

@@ directional_texture_shade.f @@
+incdir+sv
sv/dts_pkg.sv
sv/dts_ram.sv
sv/dts_fifo.sv
sv/dts_front.sv
sv/dts_back.sv
sv/directional_texture_shade.sv
tb/dts_checker.sv
tb/directional_texture_shade_tb.sv
